@@ sv/adc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adc_pkg
// Types, codes and helper functions shared by the automatic door controller.
// ----------------------------------------------------------------------------
package adc_pkg;

  localparam int unsigned HoldW = 16;
  localparam logic [HoldW-1:0] HoldReset = 16'd1100;

  typedef enum logic [1:0] {
    MotStop = 2'd0,
    MotUp   = 2'd1,
    MotDown = 2'd2
  } motor_e;

  typedef enum logic [2:0] {
    ManIdle = 3'b001,
    ManDown = 3'b010,
    ManUp   = 3'b100
  } man_e;

  typedef enum logic [6:0] {
    DoorInit         = 7'b0000001,
    DoorOpening      = 7'b0000010,
    DoorOpenRetreat  = 7'b0000100,
    DoorOpen         = 7'b0001000,
    DoorClosing      = 7'b0010000,
    DoorCloseRetreat = 7'b0100000,
    DoorClosed       = 7'b1000000
  } door_e;

  typedef struct packed {
    logic btn_down;
    logic key_up;
    logic stop_up;
    logic limit_down;
    logic warning_up;
    logic floor_clear;
    logic presence;
    logic motor_overload;
    logic power_ok;
  } sense_t;

  typedef struct packed {
    man_e   man;
    door_e  door;
    motor_e mot;
    logic   sup;
  } ctrl_t;

  function automatic logic [2:0] door_code(door_e d);
    logic [2:0] c;
    unique case (d)
      DoorInit:         c = 3'd0;
      DoorOpening:      c = 3'd1;
      DoorOpenRetreat:  c = 3'd2;
      DoorOpen:         c = 3'd3;
      DoorClosing:      c = 3'd4;
      DoorCloseRetreat: c = 3'd5;
      DoorClosed:       c = 3'd6;
      default:          c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] man_code(man_e m);
    logic [1:0] c;
    unique case (m)
      ManIdle: c = 2'd0;
      ManDown: c = 2'd1;
      ManUp:   c = 2'd2;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/adc_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adc_step
// Next-state logic for one tick: manual and automatic door machines, motor
// command, supply request and saturating open-hold timer.
// ----------------------------------------------------------------------------
module adc_step #(
  parameter int unsigned TimerW = 16
) (
  input  adc_pkg::ctrl_t                 state_i,
  input  logic [TimerW-1:0]              timer_i,
  input  logic [adc_pkg::HoldW-1:0]      hold_i,
  input  adc_pkg::sense_t                sense_i,
  output adc_pkg::ctrl_t                 state_o,
  output logic [TimerW-1:0]              timer_o
);

  localparam int unsigned CmpW = (TimerW > adc_pkg::HoldW) ? TimerW : adc_pkg::HoldW;

  logic [TimerW-1:0] tmr;
  logic              pwr;

  assign pwr = sense_i.power_ok;

  always_comb begin
    state_o = state_i;
    tmr     = timer_i;

    unique case (state_i.man)
      adc_pkg::ManIdle: begin
        unique case (state_i.door)
          adc_pkg::DoorInit: begin
            state_o.sup = 1'b1;
            if (pwr) begin
              state_o.door = adc_pkg::DoorOpening;
              state_o.mot  = adc_pkg::MotUp;
            end
          end
          adc_pkg::DoorOpening: begin
            if (sense_i.warning_up || sense_i.motor_overload) begin
              state_o.mot  = adc_pkg::MotDown;
              state_o.door = adc_pkg::DoorOpenRetreat;
            end
            if (sense_i.stop_up) begin
              state_o.mot  = adc_pkg::MotStop;
              state_o.door = adc_pkg::DoorOpen;
              tmr          = '0;
            end
          end
          adc_pkg::DoorOpenRetreat: begin
            if (!sense_i.floor_clear || sense_i.motor_overload || sense_i.limit_down) begin
              state_o.mot  = adc_pkg::MotUp;
              state_o.door = adc_pkg::DoorOpening;
            end
          end
          adc_pkg::DoorOpen: begin
            if (sense_i.presence) tmr = '0;
            if (CmpW'(tmr) >= CmpW'(hold_i)) begin
              tmr         = '0;
              state_o.sup = 1'b1;
              if (pwr) begin
                state_o.mot  = adc_pkg::MotDown;
                state_o.door = adc_pkg::DoorClosing;
              end
            end
          end
          adc_pkg::DoorClosing: begin
            if (!sense_i.floor_clear || sense_i.motor_overload) begin
              state_o.mot  = adc_pkg::MotUp;
              state_o.door = adc_pkg::DoorCloseRetreat;
            end
            if (sense_i.limit_down) begin
              state_o.mot  = adc_pkg::MotStop;
              state_o.door = adc_pkg::DoorClosed;
            end
            if (sense_i.presence) begin
              state_o.mot  = adc_pkg::MotUp;
              state_o.door = adc_pkg::DoorOpening;
            end
          end
          adc_pkg::DoorCloseRetreat: begin
            if (sense_i.warning_up || sense_i.motor_overload || sense_i.stop_up) begin
              state_o.mot  = adc_pkg::MotDown;
              state_o.door = adc_pkg::DoorClosing;
            end
            if (sense_i.presence) begin
              state_o.mot  = adc_pkg::MotUp;
              state_o.door = adc_pkg::DoorOpening;
            end
          end
          adc_pkg::DoorClosed: begin
            if (pwr) state_o.sup = 1'b0;
            if (sense_i.presence || !sense_i.floor_clear) begin
              state_o.sup = 1'b1;
              if (pwr) begin
                state_o.mot  = adc_pkg::MotUp;
                state_o.door = adc_pkg::DoorOpening;
              end
            end
          end
          default: ;
        endcase
        if (sense_i.btn_down) begin
          state_o.sup = 1'b1;
          if (pwr) state_o.man = adc_pkg::ManDown;
        end
        if (sense_i.key_up) begin
          state_o.sup = 1'b1;
          if (pwr) state_o.man = adc_pkg::ManUp;
        end
      end
      adc_pkg::ManDown: begin
        if (!sense_i.btn_down) begin
          state_o.mot  = adc_pkg::MotStop;
          state_o.sup  = 1'b0;
          if (!pwr) state_o.man = adc_pkg::ManIdle;
          state_o.door = adc_pkg::DoorOpen;
        end
        if (sense_i.limit_down) begin
          state_o.mot  = adc_pkg::MotStop;
          state_o.man  = adc_pkg::ManIdle;
          state_o.door = adc_pkg::DoorClosed;
        end
        if (state_o.man == adc_pkg::ManDown) state_o.mot = adc_pkg::MotDown;
      end
      adc_pkg::ManUp: begin
        if (!sense_i.key_up) begin
          state_o.mot  = adc_pkg::MotStop;
          state_o.sup  = 1'b0;
          if (!pwr) state_o.man = adc_pkg::ManIdle;
          state_o.door = adc_pkg::DoorOpen;
        end
        if (sense_i.stop_up) begin
          state_o.mot  = adc_pkg::MotStop;
          state_o.man  = adc_pkg::ManIdle;
          state_o.door = adc_pkg::DoorOpen;
        end
        if (state_o.man == adc_pkg::ManUp) state_o.mot = adc_pkg::MotUp;
      end
      default: ;
    endcase

    // saturating tick count
    timer_o = (tmr == '1) ? tmr : tmr + 1'b1;
  end

endmodule
`default_nettype wire

@@ sv/auto_door_controller_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// auto_door_controller_unit
// Automatic door controller with obstacle reversal; one item per tick.
// Each accepted input passes through the input register, then the state/result
// register. Throughput: one item per cycle while the output is not stalled.
// Reset: door init, manual idle, motor stopped, supply off, timer zero,
// open hold 1100 ticks.
// ----------------------------------------------------------------------------
module auto_door_controller_unit #(
  parameter int unsigned HOLD_TIMER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [adc_pkg::HoldW-1:0]   cfg_open_hold_ticks_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        btn_down_i,
  input  logic                        key_up_i,
  input  logic                        stop_up_i,
  input  logic                        limit_down_i,
  input  logic                        warning_up_i,
  input  logic                        floor_clear_i,
  input  logic                        outdoor_presence_i,
  input  logic                        indoor_presence_i,
  input  logic                        motor_overload_i,
  input  logic                        power_ok_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  motor_drive_o,
  output logic                        supply_enable_o,
  output logic [2:0]                  door_mode_o,
  output logic [1:0]                  manual_mode_o
);

  logic [adc_pkg::HoldW-1:0] hold_q;
  logic                      in_vld_q;
  adc_pkg::sense_t           sense_q;
  logic                      out_vld_q;
  adc_pkg::ctrl_t            state_q, state_d;
  logic [HOLD_TIMER_BITS-1:0] timer_q, timer_d;
  logic                      advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= adc_pkg::HoldReset;
    end else if (cfg_we_i) begin
      hold_q <= cfg_open_hold_ticks_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sense_q.btn_down       <= btn_down_i;
      sense_q.key_up         <= key_up_i;
      sense_q.stop_up        <= stop_up_i;
      sense_q.limit_down     <= limit_down_i;
      sense_q.warning_up     <= warning_up_i;
      sense_q.floor_clear    <= floor_clear_i;
      sense_q.presence       <= outdoor_presence_i | indoor_presence_i;
      sense_q.motor_overload <= motor_overload_i;
      sense_q.power_ok       <= power_ok_i;
    end
  end

  adc_step #(
    .TimerW(HOLD_TIMER_BITS)
  ) u_step (
    .state_i(state_q),
    .timer_i(timer_q),
    .hold_i (hold_q),
    .sense_i(sense_q),
    .state_o(state_d),
    .timer_o(timer_d)
  );

  // state registers double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      state_q.man  <= adc_pkg::ManIdle;
      state_q.door <= adc_pkg::DoorInit;
      state_q.mot  <= adc_pkg::MotStop;
      state_q.sup  <= 1'b0;
      timer_q      <= '0;
    end else begin
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
        timer_q   <= timer_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign motor_drive_o   = state_q.mot;
  assign supply_enable_o = state_q.sup;
  assign door_mode_o     = adc_pkg::door_code(state_q.door);
  assign manual_mode_o   = adc_pkg::man_code(state_q.man);

endmodule
`default_nettype wire
